@@ hw/rtl/sbo_pkg.sv @@
// ---------------------------------------------------------------------------
// sbo_pkg
// Shared widths, command codes and types for the sphere/box overlap core.
// ---------------------------------------------------------------------------
package sbo_pkg;

    localparam int CW   = 16;            // coordinate width, signed offsets
    localparam int SZW  = CW - 1;        // size field width
    localparam int XW   = CW;            // doubled sphere radius / box extent
    localparam int EW   = CW + 1;        // doubled absolute offset
    localparam int DW   = 2 * EW + 2;    // squared centre distance, doubled units
    localparam int PW   = 2 * CW;        // squared doubled radius / box diagonal
    localparam int TLW  = (DW + 1) / 2;  // low half of the distance excess
    localparam int THW  = DW - TLW;      // high half of the distance excess
    localparam int PLW  = PW / 2;        // low half of a squared radius
    localparam int PHW  = PW - PLW;      // high half of a squared radius
    localparam int LW   = 2 * DW;        // final compare width

    typedef enum logic [1:0] {
        CMD_SPH_SPH = 2'd0,
        CMD_SPH_BOX = 2'd1,
        CMD_BOX_SPH = 2'd2,
        CMD_BOX_BOX = 2'd3
    } t_cmd;

    typedef struct packed {
        logic need_axis;
        logic axis_ok;
    } t_flags;

endpackage

@@ hw/rtl/sbo_if.sv @@
// ---------------------------------------------------------------------------
// sbo_if
// Valid/ready channels of the overlap core: query words in, result words out.
// ---------------------------------------------------------------------------
interface sbo_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic signed [sbo_pkg::CW-1:0]   offset_x;
    logic signed [sbo_pkg::CW-1:0]   offset_y;
    logic signed [sbo_pkg::CW-1:0]   offset_z;
    logic [sbo_pkg::SZW-1:0]         size_a_x;
    logic [sbo_pkg::SZW-1:0]         size_a_y;
    logic [sbo_pkg::SZW-1:0]         size_a_z;
    logic [sbo_pkg::SZW-1:0]         size_b_x;
    logic [sbo_pkg::SZW-1:0]         size_b_y;
    logic [sbo_pkg::SZW-1:0]         size_b_z;

    modport source (
        output valid, command, offset_x, offset_y, offset_z,
               size_a_x, size_a_y, size_a_z, size_b_x, size_b_y, size_b_z,
        input  ready
    );
    modport sink (
        input  valid, command, offset_x, offset_y, offset_z,
               size_a_x, size_a_y, size_a_z, size_b_x, size_b_y, size_b_z,
        output ready
    );
endinterface

interface sbo_rsp_if;
    logic valid;
    logic ready;
    logic collided;

    modport source (output valid, collided, input ready);
    modport sink   (input valid, collided, output ready);
endinterface

@@ hw/rtl/sphere_box_overlap_test_core.sv @@
// ---------------------------------------------------------------------------
// sphere_box_overlap_test_core
// Exact sphere/box overlap test on doubled fixed-point values and squared
// distances, as a seven stage pipeline.
// ---------------------------------------------------------------------------
//  channel | dir | word
//  i_req   | in  | command, offset_x/y/z, size_a_x/y/z, size_b_x/y/z
//  o_rsp   | out | collided
//
//  One query per cycle is sustained while o_rsp is not stalled. Stages: operand
//  prep, squares, sums, excess, split products, wide sums, final compare.
//  Reset clears only the stage valid bits.
//  Each stage holds while the one after it is full and stalled, so a stall
//  at the output fills bubbles before it backs up to i_req.ready.
// ---------------------------------------------------------------------------
module sphere_box_overlap_test_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbo_req_if.sink      i_req,
    sbo_rsp_if.source    o_rsp
);

    localparam int CW  = sbo_pkg::CW;
    localparam int XW  = sbo_pkg::XW;
    localparam int EW  = sbo_pkg::EW;
    localparam int DW  = sbo_pkg::DW;
    localparam int PW  = sbo_pkg::PW;
    localparam int TLW = sbo_pkg::TLW;
    localparam int THW = sbo_pkg::THW;
    localparam int PLW = sbo_pkg::PLW;
    localparam int PHW = sbo_pkg::PHW;
    localparam int LW  = sbo_pkg::LW;
    localparam int NS  = 7;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: doubled |offset|, per-axis extents
    logic            n_abox, n_bbox;
    logic [EW-1:0]   n_e  [3];
    logic [XW-1:0]   n_xa [3];
    logic [XW-1:0]   n_xb [3];
    logic            r1_abox, r1_bbox;
    logic [EW-1:0]   r1_e  [3];
    logic [XW-1:0]   r1_xa [3];
    logic [XW-1:0]   r1_xb [3];

    logic signed [CW-1:0] off [3];
    logic signed [CW:0]   off_x;
    logic [CW:0]          mag;

    always_comb begin
        n_abox = (sbo_pkg::t_cmd'(i_req.command) == sbo_pkg::CMD_BOX_SPH) ||
                 (sbo_pkg::t_cmd'(i_req.command) == sbo_pkg::CMD_BOX_BOX);
        n_bbox = (sbo_pkg::t_cmd'(i_req.command) == sbo_pkg::CMD_SPH_BOX) ||
                 (sbo_pkg::t_cmd'(i_req.command) == sbo_pkg::CMD_BOX_BOX);
        off[0] = i_req.offset_x;
        off[1] = i_req.offset_y;
        off[2] = i_req.offset_z;
        off_x  = '0;
        mag    = '0;
        for (int i = 0; i < 3; i++) begin
            off_x  = {off[i][CW-1], off[i]};
            mag    = off_x[CW] ? (CW+1)'(-off_x) : (CW+1)'(off_x);
            n_e[i] = {mag[CW-1:0], 1'b0};
        end
        n_xa[0] = n_abox ? {1'b0, i_req.size_a_x} : {i_req.size_a_x, 1'b0};
        n_xa[1] = n_abox ? {1'b0, i_req.size_a_y} : {i_req.size_a_x, 1'b0};
        n_xa[2] = n_abox ? {1'b0, i_req.size_a_z} : {i_req.size_a_x, 1'b0};
        n_xb[0] = n_bbox ? {1'b0, i_req.size_b_x} : {i_req.size_b_x, 1'b0};
        n_xb[1] = n_bbox ? {1'b0, i_req.size_b_y} : {i_req.size_b_x, 1'b0};
        n_xb[2] = n_bbox ? {1'b0, i_req.size_b_z} : {i_req.size_b_x, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_abox <= n_abox;
            r1_bbox <= n_bbox;
            r1_e    <= n_e;
            r1_xa   <= n_xa;
            r1_xb   <= n_xb;
        end
    end

    // stage 2: squares and per-axis extent test
    logic [2*EW-1:0]  r2_dq [3];
    logic [2*XW-1:0]  r2_aq [3];
    logic [2*XW-1:0]  r2_bq [3];
    sbo_pkg::t_flags  r2_f;
    logic [XW-1:0]    sq_a [3];
    logic [XW-1:0]    sq_b [3];
    logic [XW:0]      ext_sum;
    logic             n_axis_ok;

    always_comb begin
        sq_a[0]   = r1_xa[0];
        sq_b[0]   = r1_xb[0];
        n_axis_ok = 1'b1;
        ext_sum   = '0;
        for (int i = 1; i < 3; i++) begin
            sq_a[i] = r1_abox ? r1_xa[i] : '0;
            sq_b[i] = r1_bbox ? r1_xb[i] : '0;
        end
        for (int i = 0; i < 3; i++) begin
            ext_sum = {1'b0, r1_xa[i]} + {1'b0, r1_xb[i]};
            if (r1_e[i] > ext_sum) begin
                n_axis_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_dq[i] <= r1_e[i] * r1_e[i];
                r2_aq[i] <= sq_a[i] * sq_a[i];
                r2_bq[i] <= sq_b[i] * sq_b[i];
            end
            r2_f.need_axis <= r1_abox || r1_bbox;
            r2_f.axis_ok   <= n_axis_ok;
        end
    end

    // stage 3: squared distance and squared reach of each shape
    logic [DW-1:0]    r3_d;
    logic [PW-1:0]    r3_pa, r3_pb;
    sbo_pkg::t_flags  r3_f;
    logic [2*XW+1:0]  pa_sum, pb_sum;

    assign pa_sum = (2*XW+2)'(r2_aq[0]) + (2*XW+2)'(r2_aq[1]) + (2*XW+2)'(r2_aq[2]);
    assign pb_sum = (2*XW+2)'(r2_bq[0]) + (2*XW+2)'(r2_bq[1]) + (2*XW+2)'(r2_bq[2]);

    // sizes are at most CW-1 bits, so either reach fits in PW bits
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_d  <= DW'(r2_dq[0]) + DW'(r2_dq[1]) + DW'(r2_dq[2]);
            r3_pa <= pa_sum[PW-1:0];
            r3_pb <= pb_sum[PW-1:0];
            r3_f  <= r2_f;
        end
    end

    // stage 4: excess of distance over the sum of reaches
    logic [DW-1:0]    r4_t;
    logic             r4_le;
    logic [PW-1:0]    r4_pa, r4_pb;
    sbo_pkg::t_flags  r4_f;
    logic [DW-1:0]    s_ext;

    assign s_ext = DW'(r3_pa) + DW'(r3_pb);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_le <= r3_d <= s_ext;
            r4_t  <= r3_d - s_ext;
            r4_pa <= r3_pa;
            r4_pb <= r3_pb;
            r4_f  <= r3_f;
        end
    end

    // stage 5: split products for excess^2 and pa*pb
    logic [2*THW-1:0]     r5_thh;
    logic [THW+TLW-1:0]   r5_thl;
    logic [2*TLW-1:0]     r5_tll;
    logic [2*PHW-1:0]     r5_phh;
    logic [PHW+PLW-1:0]   r5_phl;
    logic [PHW+PLW-1:0]   r5_plh;
    logic [2*PLW-1:0]     r5_pll;
    logic                 r5_le;
    sbo_pkg::t_flags      r5_f;
    logic [THW-1:0]       t_hi;
    logic [TLW-1:0]       t_lo;
    logic [PHW-1:0]       pa_hi, pb_hi;
    logic [PLW-1:0]       pa_lo, pb_lo;

    assign t_hi  = r4_t[DW-1:TLW];
    assign t_lo  = r4_t[TLW-1:0];
    assign pa_hi = r4_pa[PW-1:PLW];
    assign pa_lo = r4_pa[PLW-1:0];
    assign pb_hi = r4_pb[PW-1:PLW];
    assign pb_lo = r4_pb[PLW-1:0];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_thh <= t_hi * t_hi;
            r5_thl <= t_hi * t_lo;
            r5_tll <= t_lo * t_lo;
            r5_phh <= pa_hi * pb_hi;
            r5_phl <= pa_hi * pb_lo;
            r5_plh <= pa_lo * pb_hi;
            r5_pll <= pa_lo * pb_lo;
            r5_le  <= r4_le;
            r5_f   <= r4_f;
        end
    end

    // stage 6: assemble excess^2 and 4*pa*pb
    logic [LW-1:0]    r6_lhs, r6_rhs;
    logic             r6_le;
    sbo_pkg::t_flags  r6_f;
    logic [LW-1:0]    n_lhs, n_rhs;

    always_comb begin
        n_lhs = (LW'(r5_thh) << (2*TLW)) + (LW'(r5_thl) << (TLW+1)) + LW'(r5_tll);
        n_rhs = ((LW'(r5_phh) << (2*PLW)) + (LW'(r5_phl) << PLW) +
                 (LW'(r5_plh) << PLW) + LW'(r5_pll)) << 2;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_lhs <= n_lhs;
            r6_rhs <= n_rhs;
            r6_le  <= r5_le;
            r6_f   <= r5_f;
        end
    end

    // stage 7: final decision, output register
    logic r7_hit;
    logic reach;

    assign reach = r6_le || (r6_lhs <= r6_rhs);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_hit <= reach && (!r6_f.need_axis || r6_f.axis_ok);
        end
    end

    assign o_rsp.valid    = r_v[NS-1];
    assign o_rsp.collided = r7_hit;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere/box overlap core. Queries are driven in
// bursts on i_req. Each accepted query is scored by an exact integer
// predictor: a centre-distance test, then per-axis extents for pairs that
// hold a box. The collided bit of each result word on o_rsp is compared in
// order against the predictions. Runs a directed set, then two random phases.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CW               = sbo_pkg::CW;
    localparam int SZW              = sbo_pkg::SZW;
    localparam int STALL_LIMIT      = 1000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PHASE_LEN = 250;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 150;

    typedef enum logic [1:0] {
        RCV_OPEN,
        RCV_COIN,
        RCV_SPARSE,
        RCV_PERIODIC
    } t_rcv_mode;

    typedef struct packed {
        sbo_pkg::t_cmd        command;
        logic [2:0][CW-1:0]   offset;
        logic [2:0][SZW-1:0]  size_a;
        logic [2:0][SZW-1:0]  size_b;
    } t_query;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sbo_req_if req_if ();
    sbo_rsp_if rsp_if ();

    sphere_box_overlap_test_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    t_query     query_q [$];
    logic       collided_exp_q [$];
    t_query     cur_query = '0;
    int         burst_left;
    int         gap_left;
    int         result_count;
    int         mismatch_count = 0;
    int         idle_cycles;
    int         hold_left;
    int         pattern_left;
    logic       long_hold_done;
    t_rcv_mode  pattern_mode;

    assign req_if.command  = cur_query.command;
    assign req_if.offset_x = cur_query.offset[0];
    assign req_if.offset_y = cur_query.offset[1];
    assign req_if.offset_z = cur_query.offset[2];
    assign req_if.size_a_x = cur_query.size_a[0];
    assign req_if.size_a_y = cur_query.size_a[1];
    assign req_if.size_a_z = cur_query.size_a[2];
    assign req_if.size_b_x = cur_query.size_b[0];
    assign req_if.size_b_y = cur_query.size_b[1];
    assign req_if.size_b_z = cur_query.size_b[2];

    // Exact overlap decision on doubled values and squared distances.
    function automatic logic predict_collided(t_query q);
        logic [127:0] mag [3];
        logic [127:0] dist2, rad2_a, rad2_b, rsum, excess, ext_a, ext_b;
        logic         a_box, b_box, hit;
        longint       v;
        a_box  = (q.command == sbo_pkg::CMD_BOX_SPH) || (q.command == sbo_pkg::CMD_BOX_BOX);
        b_box  = (q.command == sbo_pkg::CMD_SPH_BOX) || (q.command == sbo_pkg::CMD_BOX_BOX);
        dist2  = '0;
        rad2_a = '0;
        rad2_b = '0;
        for (int i = 0; i < 3; i++) begin
            v      = longint'($signed(q.offset[i]));
            mag[i] = 128'(v < 0 ? -v : v) << 1;
            dist2  = dist2 + mag[i] * mag[i];
            if (a_box)
                rad2_a = rad2_a + 128'(q.size_a[i]) * 128'(q.size_a[i]);
            if (b_box)
                rad2_b = rad2_b + 128'(q.size_b[i]) * 128'(q.size_b[i]);
        end
        if (!a_box)
            rad2_a = (128'(q.size_a[0]) << 1) * (128'(q.size_a[0]) << 1);
        if (!b_box)
            rad2_b = (128'(q.size_b[0]) << 1) * (128'(q.size_b[0]) << 1);

        hit  = 1'b1;
        rsum = rad2_a + rad2_b;
        if (dist2 > rsum) begin
            excess = dist2 - rsum;
            if (excess * excess > 4 * rad2_a * rad2_b)
                hit = 1'b0;
        end
        if (hit && (a_box || b_box)) begin
            for (int i = 0; i < 3; i++) begin
                ext_a = a_box ? 128'(q.size_a[i]) : 128'(q.size_a[0]) << 1;
                ext_b = b_box ? 128'(q.size_b[i]) : 128'(q.size_b[0]) << 1;
                if (mag[i] > ext_a + ext_b)
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int     sh, axis, span, ext_a, ext_b, pick;
        logic   a_box, b_box;
        q.command = sbo_pkg::t_cmd'($urandom_range(0, 3));
        a_box = (q.command == sbo_pkg::CMD_BOX_SPH) || (q.command == sbo_pkg::CMD_BOX_BOX);
        b_box = (q.command == sbo_pkg::CMD_SPH_BOX) || (q.command == sbo_pkg::CMD_BOX_BOX);
        pick  = $urandom_range(0, 99);
        if (pick < 25) begin
            for (int i = 0; i < 3; i++) begin
                q.offset[i] = CW'($urandom);
                q.size_a[i] = SZW'($urandom);
                q.size_b[i] = SZW'($urandom);
            end
        end else if (pick < 70) begin
            // one random scale for all fields: near misses as often as hits
            sh = $urandom_range(1, SZW);
            for (int i = 0; i < 3; i++) begin
                q.offset[i] = CW'(int'($urandom_range(0, (2 << sh) - 1)) - (1 << sh));
                q.size_a[i] = SZW'($urandom_range(0, (1 << sh) - 1));
                q.size_b[i] = SZW'($urandom_range(0, (1 << sh) - 1));
            end
        end else begin
            // shapes just touching along one axis, give or take one LSB
            axis = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                q.offset[i] = CW'(int'($urandom_range(0, 64)) - 32);
                q.size_a[i] = SZW'($urandom_range(0, 16383));
                q.size_b[i] = SZW'($urandom_range(0, 16383));
            end
            if (!a_box)
                q.size_a[0] = SZW'($urandom_range(0, 8191));
            if (!b_box)
                q.size_b[0] = SZW'($urandom_range(0, 8191));
            ext_a = a_box ? int'(q.size_a[axis]) : 2 * int'(q.size_a[0]);
            ext_b = b_box ? int'(q.size_b[axis]) : 2 * int'(q.size_b[0]);
            span  = (ext_a + ext_b) / 2 + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1)
                span = -span;
            q.offset[axis] = CW'(span);
        end
        return q;
    endfunction

    task automatic push_query(sbo_pkg::t_cmd cmd, int ox, int oy, int oz,
                              int ax, int ay, int az, int bx, int by, int bz);
        t_query q;
        q.command   = cmd;
        q.offset[0] = CW'(ox);
        q.offset[1] = CW'(oy);
        q.offset[2] = CW'(oz);
        q.size_a[0] = SZW'(ax);
        q.size_a[1] = SZW'(ay);
        q.size_a[2] = SZW'(az);
        q.size_b[0] = SZW'(bx);
        q.size_b[1] = SZW'(by);
        q.size_b[2] = SZW'(bz);
        query_q.push_back(q);
    endtask

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic wait_idle();
        while (query_q.size() != 0 || req_if.valid || collided_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else begin
            if (req_if.valid && req_if.ready)
                collided_exp_q.push_back(predict_collided(cur_query));
            if (!req_if.valid || req_if.ready) begin
                if (gap_left != 0) begin
                    req_if.valid <= 1'b0;
                    gap_left     <= gap_left - 1;
                end else if (query_q.size() != 0) begin
                    cur_query    <= query_q.pop_front();
                    req_if.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: one of four stall patterns, redrawn at random, and one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready   <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            pattern_left   <= 0;
            pattern_mode   <= RCV_OPEN;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (result_count >= LONG_HOLD_AT && !long_hold_done) begin
            rsp_if.ready   <= 1'b0;
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_mode <= t_rcv_mode'($urandom_range(0, 3));
                pattern_left <= $urandom_range(16, 96);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (pattern_mode)
                RCV_OPEN: begin
                    rsp_if.ready <= 1'b1;
                end
                RCV_COIN: begin
                    rsp_if.ready <= 1'($urandom_range(0, 1));
                end
                RCV_SPARSE: begin
                    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    rsp_if.ready <= (pattern_left % 5 < 3);
                end
            endcase
        end
    end

    // monitor: in-order compare of result words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_count <= 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            result_count <= result_count + 1;
            if (collided_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word, collided=%b", rsp_if.collided));
            end else if (rsp_if.collided !== collided_exp_q[0]) begin
                report_mismatch($sformatf("word %0d collided=%b, want %b",
                                          result_count, rsp_if.collided, collided_exp_q[0]));
                void'(collided_exp_q.pop_front());
            end else begin
                void'(collided_exp_q.pop_front());
            end
        end
    end

    // watchdog: cycles without a handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // touching spheres count as collided, one LSB further apart do not
        push_query(sbo_pkg::CMD_SPH_SPH, 150, 0, 0, 100, 0, 0, 50, 0, 0);
        push_query(sbo_pkg::CMD_SPH_SPH, 151, 0, 0, 100, 0, 0, 50, 0, 0);
        // touching off axis; sphere y/z sizes must be ignored
        push_query(sbo_pkg::CMD_SPH_SPH, 30, 40, 0, 25, 32767, 32767, 25, 32767, 0);
        push_query(sbo_pkg::CMD_SPH_SPH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_query(sbo_pkg::CMD_SPH_SPH, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        push_query(sbo_pkg::CMD_SPH_SPH, -32768, -32768, -32768, 32767, 0, 0, 32767, 0, 0);
        push_query(sbo_pkg::CMD_SPH_SPH, 32767, 32767, 32767, 0, 32767, 32767,
                   0, 32767, 32767);
        // boxes touching face to face, then apart
        push_query(sbo_pkg::CMD_BOX_BOX, 100, 0, 0, 100, 100, 100, 100, 100, 100);
        push_query(sbo_pkg::CMD_BOX_BOX, 101, 0, 0, 100, 100, 100, 100, 100, 100);
        // bounding spheres reach; x extents touch, then miss by one LSB
        push_query(sbo_pkg::CMD_BOX_BOX, 10, 0, 0, 10, 1000, 0, 10, 1000, 0);
        push_query(sbo_pkg::CMD_BOX_BOX, 11, 0, 0, 10, 1000, 0, 10, 1000, 0);
        push_query(sbo_pkg::CMD_BOX_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_query(sbo_pkg::CMD_BOX_BOX, -32768, 32767, -32768, 32767, 32767, 32767,
                   32767, 32767, 32767);
        // sphere against box face, and against the corner region
        push_query(sbo_pkg::CMD_SPH_BOX, 100, 0, 0, 50, 7, 9, 100, 100, 100);
        push_query(sbo_pkg::CMD_SPH_BOX, 100, 100, 100, 50, 0, 0, 100, 100, 100);
        push_query(sbo_pkg::CMD_BOX_SPH, -100, 0, 0, 100, 100, 100, 50, 3, 5);
        push_query(sbo_pkg::CMD_BOX_SPH, -100, -100, -100, 100, 100, 100, 50, 0, 0);
        push_query(sbo_pkg::CMD_SPH_BOX, 5, -5, 0, 0, 32767, 32767, 20, 20, 20);
        push_query(sbo_pkg::CMD_SPH_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                   32767, 32767, 32767);
        push_query(sbo_pkg::CMD_BOX_SPH, 32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767, 32767);
        push_query(sbo_pkg::CMD_BOX_SPH, 1, 1, 1, 0, 0, 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_idle();
        repeat (RANDOM_PHASE_LEN) query_q.push_back(random_query());
        // sender pauses here until every word is back
        wait_idle();
        repeat (RANDOM_PHASE_LEN) query_q.push_back(random_query());

        while (query_q.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (collided_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && collided_exp_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sbo_pkg.sv
hw/rtl/sbo_if.sv
hw/rtl/sphere_box_overlap_test_core.sv
test/tb_top.sv
